/* rtl/tti_pkg.sv */
// Shared types and constants of the trilinear table interpolator.
`default_nettype none

package tti_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = 12;
	localparam int WORD_W      = 32;
	localparam int DIST_W      = 24;
	localparam int FRAC_W      = 16;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	localparam int SIZE_X_DEF  = 16;
	localparam int SIZE_Y_DEF  = 16;
	localparam int SIZE_Z_DEF  = 16;

	localparam logic [DIST_W-1:0] INV_STEP_RESET = 24'd65536;

	typedef enum logic [2:0] {
		REG_LOW_X      = 3'd0,
		REG_LOW_Y      = 3'd1,
		REG_LOW_Z      = 3'd2,
		REG_INV_STEP_X = 3'd3,
		REG_INV_STEP_Y = 3'd4,
		REG_INV_STEP_Z = 3'd5
	} reg_idx_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_EVAL  = 1'b1
	} req_t;

endpackage

`default_nettype wire

/* rtl/tti_lerp.sv */
// Two-stage linear blend a + round((b - a) * w / 65536), ties toward +inf.
`default_nettype none

module tti_lerp (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire logic signed [tti_pkg::WORD_W-1:0] a,
	input  wire logic signed [tti_pkg::WORD_W-1:0] b,
	input  wire logic [tti_pkg::FRAC_W-1:0]        w,
	output logic signed [tti_pkg::WORD_W-1:0]      r
);

	localparam int DIFF_W = tti_pkg::WORD_W + 1;
	localparam int PROD_W = DIFF_W + tti_pkg::FRAC_W + 1;

	logic signed [DIFF_W-1:0]         diff;
	logic signed [PROD_W-1:0]         prod_s1;
	logic signed [tti_pkg::WORD_W-1:0] a_s1;
	logic signed [PROD_W-1:0]         rnd;
	logic signed [PROD_W-1:0]         sum;

	assign diff = DIFF_W'(b) - DIFF_W'(a);

	// result always lies between a and b, so the low word is exact
	assign rnd = (prod_s1 + PROD_W'(32768)) >>> tti_pkg::FRAC_W;
	assign sum = PROD_W'(a_s1) + rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff * $signed({1'b0, w});
			a_s1    <= a;
			r       <= sum[tti_pkg::WORD_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/trilinear_table_interpolator.sv */
// Top level of the trilinear table interpolator: config, table, pipeline.
`default_nettype none

// Evaluates a three-axis Q16.16 potential table by trilinear interpolation, one item per
// clock cycle sustained while no result waits on out_ready. An item with
// req_type 0 stores entry_value at flat address entry_address (z*SIZE_X*SIZE_Y +
// SIZE_Y*x + y) and returns value 0; an item with req_type 1 maps pos_x/y/z (Q8.16)
// onto the grid with the low_* and inv_step_* registers and blends the eight corner
// words. A negative base index, a base index whose neighbour falls outside its axis, or
// a far corner beyond the 4096-word store returns value 0 with out_of_range set. The
// eight corner reads come from four copies of the table, each with two read ports, so
// every copy takes every write; words never written read as garbage. The pipeline runs through
// the subtract, the three 24x24 multipliers, the address stage, the registered table read
// and seven two-stage blend units (four along x, then two along y, then one along z). The whole pipeline
// holds while a result waits on out_ready; in_ready drops only then. Write the
// registers only while no item is in flight.

module trilinear_table_interpolator #(
	parameter int SIZE_X = tti_pkg::SIZE_X_DEF,
	parameter int SIZE_Y = tti_pkg::SIZE_Y_DEF,
	parameter int SIZE_Z = tti_pkg::SIZE_Z_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration port
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [tti_pkg::PADDR_W-1:0]           paddr,
	input  wire  [tti_pkg::PDATA_W-1:0]           pwdata,
	output logic [tti_pkg::PDATA_W-1:0]           prdata,
	output logic                                  pready,
	// input items
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   req_type,
	input  wire  [tti_pkg::ADDR_W-1:0]            entry_address,
	input  wire logic signed [tti_pkg::WORD_W-1:0] entry_value,
	input  wire  [tti_pkg::DIST_W-1:0]            pos_x,
	input  wire  [tti_pkg::DIST_W-1:0]            pos_y,
	input  wire  [tti_pkg::DIST_W-1:0]            pos_z,
	// result items
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [tti_pkg::WORD_W-1:0]     value,
	output logic                                  out_of_range
);

	localparam int DW   = tti_pkg::DIST_W;
	localparam int FW   = tti_pkg::FRAC_W;
	localparam int AW   = tti_pkg::ADDR_W;
	localparam int WW   = tti_pkg::WORD_W;
	localparam int PW   = 2 * DW;
	localparam int KW   = PW - FW;          // kept product bits: base index and weight
	localparam int BW   = KW - FW;          // base index width
	localparam int LW   = 32;               // flat address arithmetic width
	localparam int NST  = 10;               // pipeline stages
	localparam logic [LW-1:0] SXY     = LW'(SIZE_X * SIZE_Y);
	localparam logic [LW-1:0] SY      = LW'(SIZE_Y);
	localparam logic [LW-1:0] FAR_OFF = LW'(SIZE_X * SIZE_Y + SIZE_Y + 1);
	localparam logic [LW-1:0] DEPTH   = LW'(tti_pkg::TABLE_DEPTH);

	// ---------------- configuration registers ----------------
	logic [DW-1:0] low_x_q, low_y_q, low_z_q;
	logic [DW-1:0] inv_x_q, inv_y_q, inv_z_q;
	logic          cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_x_q <= '0;
			low_y_q <= '0;
			low_z_q <= '0;
			inv_x_q <= tti_pkg::INV_STEP_RESET;
			inv_y_q <= tti_pkg::INV_STEP_RESET;
			inv_z_q <= tti_pkg::INV_STEP_RESET;
		end else if (cfg_we) begin
			case (tti_pkg::reg_idx_t'(paddr[4:2]))
				tti_pkg::REG_LOW_X:      low_x_q <= pwdata[DW-1:0];
				tti_pkg::REG_LOW_Y:      low_y_q <= pwdata[DW-1:0];
				tti_pkg::REG_LOW_Z:      low_z_q <= pwdata[DW-1:0];
				tti_pkg::REG_INV_STEP_X: inv_x_q <= pwdata[DW-1:0];
				tti_pkg::REG_INV_STEP_Y: inv_y_q <= pwdata[DW-1:0];
				tti_pkg::REG_INV_STEP_Z: inv_z_q <= pwdata[DW-1:0];
				default: ;              // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		case (tti_pkg::reg_idx_t'(paddr[4:2]))
			tti_pkg::REG_LOW_X:      prdata = tti_pkg::PDATA_W'(low_x_q);
			tti_pkg::REG_LOW_Y:      prdata = tti_pkg::PDATA_W'(low_y_q);
			tti_pkg::REG_LOW_Z:      prdata = tti_pkg::PDATA_W'(low_z_q);
			tti_pkg::REG_INV_STEP_X: prdata = tti_pkg::PDATA_W'(inv_x_q);
			tti_pkg::REG_INV_STEP_Y: prdata = tti_pkg::PDATA_W'(inv_y_q);
			tti_pkg::REG_INV_STEP_Z: prdata = tti_pkg::PDATA_W'(inv_z_q);
			default:                 prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// One enable for every stage: the pipeline only holds when a result waits.
	logic [NST:1] vld_s;
	logic         adv;

	assign adv       = !vld_s[NST] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], in_valid};
		end
	end

	// ---------------- stage 1: offset from grid origin ----------------
	logic          req_s1;
	logic [AW-1:0] addr_s1;
	logic [WW-1:0] val_s1;
	logic          neg_x_s1, neg_y_s1, neg_z_s1;
	logic [DW-1:0] dif_x_s1, dif_y_s1, dif_z_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1   <= req_type;
			addr_s1  <= entry_address;
			val_s1   <= entry_value;
			neg_x_s1 <= pos_x < low_x_q;
			neg_y_s1 <= pos_y < low_y_q;
			neg_z_s1 <= pos_z < low_z_q;
			// below the origin the product counts as zero
			dif_x_s1 <= (pos_x < low_x_q) ? '0 : pos_x - low_x_q;
			dif_y_s1 <= (pos_y < low_y_q) ? '0 : pos_y - low_y_q;
			dif_z_s1 <= (pos_z < low_z_q) ? '0 : pos_z - low_z_q;
		end
	end

	// ---------------- stage 2: scale by reciprocal spacing ----------------
	logic          req_s2;
	logic [AW-1:0] addr_s2;
	logic [WW-1:0] val_s2;
	logic          nb_x_s2, nb_y_s2, nb_z_s2;
	logic [KW-1:0] t_x_s2, t_y_s2, t_z_s2;
	logic [PW-1:0] prod_x, prod_y, prod_z;

	assign prod_x = PW'(dif_x_s1) * PW'(inv_x_q);
	assign prod_y = PW'(dif_y_s1) * PW'(inv_y_q);
	assign prod_z = PW'(dif_z_s1) * PW'(inv_z_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2  <= req_s1;
			addr_s2 <= addr_s1;
			val_s2  <= val_s1;
			// negative base only when the reciprocal spacing is not zero
			nb_x_s2 <= neg_x_s1 && (inv_x_q != '0);
			nb_y_s2 <= neg_y_s1 && (inv_y_q != '0);
			nb_z_s2 <= neg_z_s1 && (inv_z_q != '0);
			t_x_s2  <= prod_x[PW-1:FW];
			t_y_s2  <= prod_y[PW-1:FW];
			t_z_s2  <= prod_z[PW-1:FW];
		end
	end

	// ---------------- stage 3: range check and base address ----------------
	logic [BW-1:0] bx, by, bz;
	logic          oob_ax;
	logic [LW-1:0] base_flat, far_flat;
	logic          oob_any;

	assign bx = t_x_s2[KW-1:FW];
	assign by = t_y_s2[KW-1:FW];
	assign bz = t_z_s2[KW-1:FW];

	assign oob_ax = nb_x_s2 || nb_y_s2 || nb_z_s2
		|| (LW'(bx) + LW'(1) >= LW'(SIZE_X))
		|| (LW'(by) + LW'(1) >= LW'(SIZE_Y))
		|| (LW'(bz) + LW'(1) >= LW'(SIZE_Z));
	assign base_flat = LW'(bz) * SXY + LW'(bx) * SY + LW'(by);
	assign far_flat  = base_flat + FAR_OFF;
	assign oob_any   = oob_ax || (far_flat >= DEPTH);

	logic          req_s3;
	logic [AW-1:0] addr_s3;
	logic [WW-1:0] val_s3;
	logic          oob_s3;
	logic [AW-1:0] base_s3;
	logic [FW-1:0] wx_s3, wy_s3, wz_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s3  <= req_s2;
			addr_s3 <= addr_s2;
			val_s3  <= val_s2;
			oob_s3  <= (req_s2 == tti_pkg::REQ_EVAL) && oob_any;
			base_s3 <= base_flat[AW-1:0];
			wx_s3   <= t_x_s2[FW-1:0];
			wy_s3   <= t_y_s2[FW-1:0];
			wz_s3   <= t_z_s2[FW-1:0];
		end
	end

	// ---------------- stage 4: table write and corner reads ----------------
	// Copy k serves corner row dy = k[0], dz = k[1]; its two ports read dx = 0 and 1.
	logic                 tbl_we;
	logic signed [WW-1:0] lo_s4 [4];
	logic signed [WW-1:0] hi_s4 [4];

	assign tbl_we = adv && vld_s[3] && (req_s3 == tti_pkg::REQ_WRITE);

	for (genvar k = 0; k < 4; k++) begin : g_copy
		localparam logic [LW-1:0] OFF = LW'((k / 2) * SIZE_X * SIZE_Y + (k % 2));
		logic [WW-1:0] table_q [tti_pkg::TABLE_DEPTH];
		logic [LW-1:0] a0, a1;

		assign a0 = LW'(base_s3) + OFF;
		assign a1 = a0 + SY;

		always_ff @(posedge clk) begin
			if (tbl_we) begin
				table_q[addr_s3] <= val_s3;
			end
			if (adv) begin
				lo_s4[k] <= table_q[a0[AW-1:0]];
				hi_s4[k] <= table_q[a1[AW-1:0]];
			end
		end
	end

	logic          oob_s4, zero_s4;
	logic [FW-1:0] wx_s4, wy_s4, wz_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			oob_s4  <= oob_s3;
			zero_s4 <= (req_s3 == tti_pkg::REQ_WRITE) || oob_s3;
			wx_s4   <= wx_s3;
			wy_s4   <= wy_s3;
			wz_s4   <= wz_s3;
		end
	end

	// ---------------- stages 5 to 10: blends along x, y, z ----------------
	logic signed [WW-1:0] cx [4];
	logic signed [WW-1:0] cy [2];
	logic signed [WW-1:0] cz;

	for (genvar k = 0; k < 4; k++) begin : g_lx
		tti_lerp u_lerp (
			.clk (clk),
			.en  (adv),
			.a   (lo_s4[k]),
			.b   (hi_s4[k]),
			.w   (wx_s4),
			.r   (cx[k])
		);
	end

	logic [FW-1:0] wy_s5, wy_s6;
	logic [FW-1:0] wz_s5, wz_s6, wz_s7, wz_s8;
	logic [NST:5]  oob_s, zero_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			wy_s5  <= wy_s4;
			wy_s6  <= wy_s5;
			wz_s5  <= wz_s4;
			wz_s6  <= wz_s5;
			wz_s7  <= wz_s6;
			wz_s8  <= wz_s7;
			oob_s  <= {oob_s[NST-1:5], oob_s4};
			zero_s <= {zero_s[NST-1:5], zero_s4};
		end
	end

	for (genvar k = 0; k < 2; k++) begin : g_ly
		tti_lerp u_lerp (
			.clk (clk),
			.en  (adv),
			.a   (cx[2*k]),
			.b   (cx[2*k+1]),
			.w   (wy_s6),
			.r   (cy[k])
		);
	end

	tti_lerp u_lz (
		.clk (clk),
		.en  (adv),
		.a   (cy[0]),
		.b   (cy[1]),
		.w   (wz_s8),
		.r   (cz)
	);

	// writes and out-of-range lookups return zero
	assign value        = zero_s[NST] ? '0 : cz;
	assign out_of_range = oob_s[NST];

	// ---------------- assertions ----------------
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> value == '0)
		else $error("out_of_range result with nonzero value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(out_of_range))
		else $error("waiting result changed");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] && (req_s3 == tti_pkg::REQ_WRITE) |-> !oob_s3)
		else $error("write item flagged out of range");

	a_far_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] && (req_s3 == tti_pkg::REQ_EVAL) && !oob_s3
			|-> (LW'(base_s3) + FAR_OFF) < DEPTH)
		else $error("corner read past the table");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held without a waiting result");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of the trilinear table interpolator.
`default_nettype none

module tb;
	import tti_pkg::*;

	localparam int SX = 16;
	localparam int SY = 16;
	localparam int SZ = 16;
	localparam int SETTLE = 24;       // idle cycles after the last result, to be safe
	localparam int LONG_HOLD = 300;   // receiver hold-off that fills the pipeline

	// Predicts the block and holds expected results in order of acceptance.
	class interp_scoreboard;
		logic [DIST_W-1:0] lo [3];
		logic [DIST_W-1:0] inv [3];
		logic signed [WORD_W-1:0] words [TABLE_DEPTH];
		logic signed [WORD_W-1:0] exp_value [$];
		bit exp_oor [$];
		int errors;

		function new();
			for (int a = 0; a < 3; a++) begin
				lo[a] = '0;
				inv[a] = INV_STEP_RESET;
			end
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DIST_W-1:0] v);
			if (idx < REG_INV_STEP_X)
				lo[idx] = v;
			else
				inv[idx - REG_INV_STEP_X] = v;
		endfunction

		// Append one expected result at the tail of the queues.
		function void queue_result(logic signed [WORD_W-1:0] v, bit oor);
			exp_value = {exp_value, v};
			exp_oor = {exp_oor, oor};
		endfunction

		// Map a distance on one axis to base index and 16-bit weight.
		function bit split(int a, logic [DIST_W-1:0] pos, output int base,
				output int unsigned w);
			logic [63:0] prod;
			base = 0;
			w = 0;
			if (pos < lo[a] && inv[a] != 0)
				return 0;
			prod = (pos >= lo[a]) ? (64'(pos) - 64'(lo[a])) * 64'(inv[a]) : 64'd0;
			base = int'(prod[63:32]);
			w = prod[31:16];
			return (prod[63:32] + 64'd1) < 64'(a == 0 ? SX : (a == 1 ? SY : SZ));
		endfunction

		function longint blend(longint a, longint b, int unsigned w);
			longint s;
			s = a * longint'(65536 - w) + b * longint'(w);
			return (s + 32768) >>> 16;
		endfunction

		function longint word(int x, int y, int z);
			return longint'(words[(z * SX * SY + SY * x + y) % TABLE_DEPTH]);
		endfunction

		// Note an accepted item and queue its expected result.
		function void note(req_t kind, logic [ADDR_W-1:0] addr,
				logic signed [WORD_W-1:0] data, logic [DIST_W-1:0] px,
				logic [DIST_W-1:0] py, logic [DIST_W-1:0] pz);
			int bx, by, bz;
			int unsigned wx, wy, wz;
			longint c00, c10, c01, c11, c0, c1;
			if (kind == REQ_WRITE) begin
				words[addr] = data;
				queue_result('0, 1'b0);
				return;
			end
			if (!split(0, px, bx, wx) || !split(1, py, by, wy) || !split(2, pz, bz, wz)
					|| (bz + 1) * SX * SY + SY * (bx + 1) + by + 1 >= TABLE_DEPTH) begin
				queue_result('0, 1'b1);
				return;
			end
			c00 = blend(word(bx, by, bz), word(bx + 1, by, bz), wx);
			c10 = blend(word(bx, by + 1, bz), word(bx + 1, by + 1, bz), wx);
			c01 = blend(word(bx, by, bz + 1), word(bx + 1, by, bz + 1), wx);
			c11 = blend(word(bx, by + 1, bz + 1), word(bx + 1, by + 1, bz + 1), wx);
			c0 = blend(c00, c10, wy);
			c1 = blend(c01, c11, wy);
			queue_result(WORD_W'(blend(c0, c1, wz)), 1'b0);
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("mismatch %s: got %0d expected %0d", what, got, want);
		endtask

		// Compare one result with the oldest expectation.
		task check(logic signed [WORD_W-1:0] v, logic oor);
			if (exp_value.size() == 0) begin
				report("unexpected result", v, 0);
				return;
			end
			if (v !== exp_value[0])
				report("value", v, exp_value[0]);
			if (oor !== exp_oor[0])
				report("out_of_range", oor, exp_oor[0]);
			void'(exp_value.pop_front());
			void'(exp_oor.pop_front());
		endtask

		function int pending();
			return exp_value.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic req_type;
	logic [ADDR_W-1:0] entry_address;
	logic signed [WORD_W-1:0] entry_value;
	logic [DIST_W-1:0] pos_x, pos_y, pos_z;
	logic out_valid, out_ready;
	logic signed [WORD_W-1:0] value;
	logic out_of_range;

	interp_scoreboard sb;
	bit written [TABLE_DEPTH];
	bit send_burst, recv_burst;
	int results_seen;
	int items_sent;

	trilinear_table_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.entry_address(entry_address), .entry_value(entry_value),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .out_of_range(out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit: far beyond the slowest legal run.
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

	// Register write: setup cycle, then access cycle; hold the bus idle afterwards.
	task reg_write(reg_idx_t idx, logic [DIST_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Offer one item after a random gap; hold valid and payload until accepted.
	task send_item(req_t kind, logic [ADDR_W-1:0] addr, logic signed [WORD_W-1:0] data,
			logic [DIST_W-1:0] px, logic [DIST_W-1:0] py, logic [DIST_W-1:0] pz);
		int gap;
		if ($urandom_range(0, 15) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		entry_address <= addr;
		entry_value <= data;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(posedge clk); while (!in_ready);
		sb.note(kind, addr, data, px, py, pz);
		if (kind == REQ_WRITE)
			written[addr] = 1'b1;
		items_sent++;
	endtask

	function logic signed [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	task write_word(logic [ADDR_W-1:0] addr, logic signed [WORD_W-1:0] data);
		send_item(REQ_WRITE, addr, data, DIST_W'($urandom), DIST_W'($urandom),
			DIST_W'($urandom));
	endtask

	// Evaluate at a point; first load any corner of its cell that was never written.
	task evaluate(logic [DIST_W-1:0] px, logic [DIST_W-1:0] py, logic [DIST_W-1:0] pz);
		int bx, by, bz;
		int unsigned w;
		int a;
		if (sb.split(0, px, bx, w) && sb.split(1, py, by, w) && sb.split(2, pz, bz, w))
			for (int k = 0; k < 8; k++) begin
				a = (bz + k[2]) * SX * SY + SY * (bx + k[0]) + by + k[1];
				if (a < TABLE_DEPTH && !written[a])
					write_word(ADDR_W'(a), rand_word());
			end
		send_item(REQ_EVAL, ADDR_W'($urandom), $urandom, px, py, pz);
	endtask

	// Distance mostly inside the grid of one axis, sometimes anywhere.
	function logic [DIST_W-1:0] pick_pos(int a);
		longint span, room;
		if ($urandom_range(0, 4) == 0)
			return DIST_W'($urandom);
		room = 64'hFFFFFF - longint'(sb.lo[a]);
		span = (sb.inv[a] == 0) ? room : (longint'(16) << 32) / longint'(sb.inv[a]);
		if (span > room)
			span = room;
		return sb.lo[a] + DIST_W'($urandom_range(0, int'(span)));
	endfunction

	task load_setting(logic [DIST_W-1:0] l0, logic [DIST_W-1:0] l1, logic [DIST_W-1:0] l2,
			logic [DIST_W-1:0] s0, logic [DIST_W-1:0] s1, logic [DIST_W-1:0] s2);
		// drop valid, then drain the pipeline before touching registers
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		reg_write(REG_LOW_X, l0);
		reg_write(REG_LOW_Y, l1);
		reg_write(REG_LOW_Z, l2);
		reg_write(REG_INV_STEP_X, s0);
		reg_write(REG_INV_STEP_Y, s1);
		reg_write(REG_INV_STEP_Z, s2);
	endtask

	task random_phase(int n);
		int stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			if ($urandom_range(0, 4) == 0)
				write_word(ADDR_W'($urandom), rand_word());
			else
				evaluate(pick_pos(0), pick_pos(1), pick_pos(2));
		end
	endtask

	// Receiver: random stalls, burst stretches, and one long hold-off.
	initial begin
		int gap;
		out_ready = 1'b0;
		results_seen = 0;
		recv_burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				recv_burst = !recv_burst;
			gap = recv_burst ? 0 : $urandom_range(0, 12);
			if (results_seen == 400)
				gap = LONG_HOLD;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check(value, out_of_range);
			results_seen++;
		end
	end

	initial begin
		sb = new();
		items_sent = 0;
		send_burst = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = REQ_WRITE;
		entry_address = '0;
		entry_value = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: address extremes, cell corners, fraction edges, axis overrun.
		write_word(ADDR_W'(0), 32'sh7FFFFFFF);
		write_word(ADDR_W'(TABLE_DEPTH - 1), 32'sh80000000);
		evaluate(24'h000000, 24'h000000, 24'h000000);
		evaluate(24'h00FFFF, 24'h00FFFF, 24'h00FFFF);
		evaluate(24'h0EFFFF, 24'h0EFFFF, 24'h0EFFFF);
		evaluate(24'h0F0000, 24'h000000, 24'h000000);
		evaluate(24'h000000, 24'h000000, 24'h0F0000);
		evaluate(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		random_phase(300);

		// Shifted origin: points below it give a negative base.
		load_setting(24'h030000, 24'h018000, 24'h000001, 24'h020000, 24'h010000,
			24'h008000);
		evaluate(24'h000000, 24'h020000, 24'h000001);
		random_phase(350);

		// Zero step: every point collapses onto the first cell.
		load_setting(24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000,
			24'h000000);
		evaluate(24'h000000, 24'hFFFFFF, 24'h123456);
		random_phase(250);

		// Extreme origin and extreme step.
		load_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF);
		evaluate(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		random_phase(100);

		load_setting(24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF);
		random_phase(250);

		// Random setting.
		load_setting(DIST_W'($urandom_range(0, 24'h0FFFFF)),
			DIST_W'($urandom_range(0, 24'h0FFFFF)),
			DIST_W'($urandom_range(0, 24'h0FFFFF)),
			DIST_W'($urandom_range(24'h002000, 24'h080000)),
			DIST_W'($urandom_range(24'h002000, 24'h080000)),
			DIST_W'($urandom_range(24'h002000, 24'h080000)));
		random_phase(550);

		// Drain and let the pipeline settle.
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
